[src/dprr_pkg.sv]
package dprr_pkg;

   // table sizes
   localparam int PAGE_COUNT   = 64;
   localparam int MAX_FRAMES   = 64;
   localparam int PAGE_W       = $clog2(PAGE_COUNT);
   localparam int FRAME_W      = $clog2(MAX_FRAMES);
   localparam int FCNT_W       = $clog2(MAX_FRAMES + 1);
   localparam int RAND_W       = 31;
   localparam int REF_W        = 32;
   localparam int STEP_W       = $clog2(RAND_W);
   localparam int FRAMES_RESET = 32;

   // action codes on the result channel
   typedef enum logic [2:0] {
      ACT_UNMAP = 3'd0,
      ACT_OUT   = 3'd1,
      ACT_IN    = 3'd2,
      ACT_ZERO  = 3'd3,
      ACT_MAP   = 3'd4
   } action_type;

   typedef struct packed {
      logic              is_write;
      logic [PAGE_W-1:0] page;
      logic [RAND_W-1:0] random_value;
   } req_type;

   typedef struct packed {
      action_type         action;
      logic [PAGE_W-1:0]  action_page;
      logic [FRAME_W-1:0] action_frame;
      logic [REF_W-1:0]   reference_number;
      logic               last;
   } rsp_type;

   // page table entry
   typedef struct packed {
      logic               present;
      logic               referenced;
      logic               modified;
      logic               swapped;
      logic [FRAME_W-1:0] frame;
   } pte_type;

endpackage

[src/demand_paging_random_replace.sv]
// accept to last action: a miss with a free frame loads then maps; a miss with eviction
// waits for the 31-step remainder unit, unmaps, pages out if modified, loads and maps;
// a hit has no action; one reference at a time; busy drops in the cycle the last action
// is out; each action is a one-cycle strobe transfer, no receiver stall
// synchronous reset clears page table valid bits, filled count, reference
// counter and sets the frame count register to 32
module demand_paging_random_replace (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  dprr_pkg::req_type           req_data,
   output logic                        rsp_strobe,
   output dprr_pkg::rsp_type           rsp_data,
   input  logic                        csr_wr_en,
   input  logic [dprr_pkg::FCNT_W-1:0] csr_wr_data
);
   import dprr_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_LOOK = 9'b000000010,
      ST_DIV  = 9'b000000100,
      ST_OWN  = 9'b000001000,
      ST_VRD  = 9'b000010000,
      ST_VCHK = 9'b000100000,
      ST_OUT  = 9'b001000000,
      ST_LOAD = 9'b010000000,
      ST_MAP  = 9'b100000000
   } state_type;

   state_type          state_ff, state_in;
   logic               wr_ff, wr_in;
   logic [PAGE_W-1:0]  pg_ff, pg_in;
   logic [RAND_W-1:0]  rnd_ff, rnd_in;
   logic [REF_W-1:0]   ref_ff, ref_in;
   logic [REF_W-1:0]   counter_ff, counter_in;
   logic [FCNT_W-1:0]  limit_ff, limit_in;
   logic [FCNT_W-1:0]  filled_ff, filled_in;
   logic [FCNT_W-1:0]  frames_cfg_ff;
   logic [FCNT_W-1:0]  limit_cur;
   pte_type            ent_ff, ent_in;
   logic [FRAME_W-1:0] fr_ff, fr_in;
   logic [PAGE_W-1:0]  victim_ff, victim_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   // page table and frame owner storage
   pte_type            pt_mem [PAGE_COUNT];
   logic [PAGE_COUNT-1:0] pt_valid_ff;
   pte_type            pt_rd_ff;
   logic               ptv_rd_ff;
   logic [PAGE_W-1:0]  pt_raddr;
   logic               pt_we;
   logic [PAGE_W-1:0]  pt_waddr;
   pte_type            pt_wdata;
   pte_type            pt_ent;
   logic [PAGE_W-1:0]  own_mem [MAX_FRAMES];
   logic [PAGE_W-1:0]  owner_rd_ff;
   logic               own_we;

   logic               mod_start;
   logic               mod_done;
   logic [FCNT_W-1:0]  mod_rem;

   dprr_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (rnd_ff),
      .divisor   (limit_ff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   // clamp the configured frame count to 1..MAX_FRAMES
   always_comb begin
      if (frames_cfg_ff == '0) begin
         limit_cur = FCNT_W'(1);
      end else if (frames_cfg_ff > FCNT_W'(MAX_FRAMES)) begin
         limit_cur = FCNT_W'(MAX_FRAMES);
      end else begin
         limit_cur = frames_cfg_ff;
      end
   end

   // unwritten entries read as zero
   assign pt_ent = ptv_rd_ff ? pt_rd_ff : '0;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      wr_in         = wr_ff;
      pg_in         = pg_ff;
      rnd_in        = rnd_ff;
      ref_in        = ref_ff;
      counter_in    = counter_ff;
      limit_in      = limit_ff;
      filled_in     = filled_ff;
      ent_in        = ent_ff;
      fr_in         = fr_ff;
      victim_in     = victim_ff;
      pt_raddr      = owner_rd_ff;
      pt_we         = 1'b0;
      pt_waddr      = pg_ff;
      pt_wdata      = pt_ent;
      own_we        = 1'b0;
      mod_start     = 1'b0;
      rsp_strobe_in = 1'b0;
      rsp_data_in.action           = ACT_ZERO;
      rsp_data_in.action_page      = pg_ff;
      rsp_data_in.action_frame     = fr_ff;
      rsp_data_in.reference_number = ref_ff;
      rsp_data_in.last             = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            pt_raddr = req_data.page;
            if (start) begin
               wr_in      = req_data.is_write;
               pg_in      = req_data.page;
               rnd_in     = req_data.random_value;
               ref_in     = counter_ff;
               counter_in = counter_ff + REF_W'(1);
               limit_in   = limit_cur;
               state_in   = ST_LOOK;
            end
         end
         ST_LOOK: begin
            ent_in = pt_ent;
            if (pt_ent.present) begin
               // hit: a write only marks the page modified
               if (wr_ff) begin
                  pt_we             = 1'b1;
                  pt_wdata.modified = 1'b1;
               end
               state_in = ST_IDLE;
            end else if (filled_ff < limit_ff) begin
               fr_in     = filled_ff[FRAME_W-1:0];
               filled_in = filled_ff + FCNT_W'(1);
               state_in  = ST_LOAD;
            end else begin
               mod_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (mod_done) begin
               fr_in    = mod_rem[FRAME_W-1:0];
               state_in = ST_OWN;
            end
         end
         ST_OWN: begin
            state_in = ST_VRD;
         end
         ST_VRD: begin
            victim_in = owner_rd_ff;
            state_in  = ST_VCHK;
         end
         ST_VCHK: begin
            // unmap the victim, mark it swapped if it goes out
            rsp_strobe_in            = 1'b1;
            rsp_data_in.action       = ACT_UNMAP;
            rsp_data_in.action_page  = victim_ff;
            pt_we                    = 1'b1;
            pt_waddr                 = victim_ff;
            pt_wdata.present         = 1'b0;
            pt_wdata.referenced      = 1'b0;
            pt_wdata.frame           = '0;
            pt_wdata.swapped         = pt_ent.swapped | pt_ent.modified;
            state_in                 = pt_ent.modified ? ST_OUT : ST_LOAD;
         end
         ST_OUT: begin
            rsp_strobe_in           = 1'b1;
            rsp_data_in.action      = ACT_OUT;
            rsp_data_in.action_page = victim_ff;
            state_in                = ST_LOAD;
         end
         ST_LOAD: begin
            rsp_strobe_in = 1'b1;
            if (ent_ff.swapped) begin
               rsp_data_in.action = ACT_IN;
            end else begin
               rsp_data_in.action      = ACT_ZERO;
               rsp_data_in.action_page = '0;
            end
            state_in = ST_MAP;
         end
         ST_MAP: begin
            rsp_strobe_in       = 1'b1;
            rsp_data_in.action  = ACT_MAP;
            rsp_data_in.last    = 1'b1;
            pt_we               = 1'b1;
            pt_wdata.present    = 1'b1;
            pt_wdata.referenced = 1'b1;
            pt_wdata.modified   = wr_ff;
            pt_wdata.swapped    = ent_ff.swapped;
            pt_wdata.frame      = fr_ff;
            own_we              = 1'b1;
            state_in            = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         counter_ff    <= '0;
         filled_ff     <= '0;
         frames_cfg_ff <= FCNT_W'(FRAMES_RESET);
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         counter_ff    <= counter_in;
         filled_ff     <= filled_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_wr_en) begin
            frames_cfg_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      wr_ff       <= wr_in;
      pg_ff       <= pg_in;
      rnd_ff      <= rnd_in;
      ref_ff      <= ref_in;
      limit_ff    <= limit_in;
      ent_ff      <= ent_in;
      fr_ff       <= fr_in;
      victim_ff   <= victim_in;
      rsp_data_ff <= rsp_data_in;
   end

   // page table valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         pt_valid_ff <= '0;
      end else if (pt_we) begin
         pt_valid_ff[pt_waddr] <= 1'b1;
      end
   end

   // page table memory
   always_ff @(posedge clock) begin
      if (pt_we) begin
         pt_mem[pt_waddr] <= pt_wdata;
      end
      pt_rd_ff  <= pt_mem[pt_raddr];
      ptv_rd_ff <= pt_valid_ff[pt_raddr];
   end

   // frame owner memory
   always_ff @(posedge clock) begin
      if (own_we) begin
         own_mem[fr_ff] <= pg_ff;
      end
      owner_rd_ff <= own_mem[fr_ff];
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // checks
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state not one-hot");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.last) |-> (state_ff == ST_IDLE))
      else $error("last action while still busy");

   a_accept_quiet: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_strobe)
      else $error("action right after accept");

   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      mod_done |-> (state_ff == ST_DIV))
      else $error("remainder done outside victim search");

   a_filled_max: assert property (@(posedge clock) disable iff (reset)
      filled_ff <= FCNT_W'(MAX_FRAMES))
      else $error("filled frame count overflow");

endmodule

[src/dprr_mod.sv]
module dprr_mod (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [dprr_pkg::RAND_W-1:0] dividend,
   input  logic [dprr_pkg::FCNT_W-1:0] divisor,
   output logic                        done,
   output logic [dprr_pkg::FCNT_W-1:0] remainder
);
   import dprr_pkg::*;

   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [FCNT_W-1:0] rem_ff, rem_in;
   logic [RAND_W-1:0] quo_ff, quo_in;
   logic [FCNT_W-1:0] div_ff, div_in;
   logic [FCNT_W:0]   shifted;
   logic [FCNT_W:0]   diff;

   // one restoring remainder step per cycle, msb first
   always_comb begin
      shifted = {rem_ff, quo_ff[RAND_W-1]};
      diff    = shifted - {1'b0, div_ff};
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         quo_in = dividend;
         div_in = divisor;
      end else if (run_ff) begin
         rem_in = (shifted >= {1'b0, div_ff}) ? diff[FCNT_W-1:0] : shifted[FCNT_W-1:0];
         quo_in = {quo_ff[RAND_W-2:0], 1'b0};
         cnt_in = cnt_ff + STEP_W'(1);
         if (cnt_ff == STEP_W'(RAND_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule
